// ===== rtl/core/hkf_pkg.sv =====
// Shared types and constants for the HTTP host keyword filter.
`timescale 1ns / 1ps

package hkf_pkg;

  localparam int NUM_KEYWORDS = 16;
  localparam int KEYWORD_LEN  = 32;
  localparam int SLOT_W       = 4;
  localparam int KW_POS_W     = $clog2(KEYWORD_LEN);
  localparam int KW_LEN_W     = 6;
  localparam int PREFIX_LEN   = 6;
  localparam int PROG_W       = 3;

  typedef enum logic [1:0] {
    MODE_KW_BYTE  = 2'd0,
    MODE_KW_LEN   = 2'd1,
    MODE_KW_CLEAR = 2'd2,
    MODE_PKT      = 2'd3
  } hkf_mode_t;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // "Host: ", index 0 is the first character
  localparam logic [PREFIX_LEN-1:0][7:0] HOST_PREFIX =
    {8'h20, 8'h3A, 8'h74, 8'h73, 8'h6F, 8'h48};

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [5:0]        position;
    logic [7:0]        data_byte;
    logic              last;
  } hkf_in_t;

  typedef struct packed {
    logic matched;
    logic host_found;
  } hkf_out_t;

  typedef logic [KEYWORD_LEN-1:0][7:0]           hkf_kw_chars_t;
  typedef hkf_kw_chars_t [NUM_KEYWORDS-1:0]       hkf_kw_bank_t;
  typedef logic [NUM_KEYWORDS-1:0][KW_LEN_W-1:0] hkf_kw_lens_t;

  typedef struct packed {
    logic text_byte;
    logic enter_host;
    logic pkt_end;
  } hkf_scan_ctl_t;

endpackage

// ===== rtl/core/http_host_keyword_filter.sv =====
// Top level of the HTTP host keyword filter.
//
//  Port group | Dir | Payload                    | Handshake
//  in_        | in  | hkf_in_t (mode..last)      | in_valid / in_ready
//  out_       | out | hkf_out_t (matched, host)  | out_valid / out_ready
//  cfg_       | in  | filter_enable, 1 bit       | cfg_valid / cfg_ready
//
// One transaction per cycle unless a held result stalls a packet end; an
// input waits in the input register and its result is registered to out_.
// Only packet bytes with last set produce a result transaction.
// A held result stalls only packet-end bytes; other bytes keep flowing.
// Synchronous active-low reset clears slot lengths, valids and packet state.
`timescale 1ns / 1ps

module http_host_keyword_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hkf_pkg::hkf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hkf_pkg::hkf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_filter_enable
);
  import hkf_pkg::*;

  logic          s1_valid_r;
  hkf_in_t       s1_item_r;
  logic          s1_res, s1_fire;
  logic          out_valid_r;
  hkf_out_t      out_data_r;
  logic          enable_r;
  hkf_kw_bank_t  kw_chars;
  hkf_kw_lens_t  kw_len;
  logic [NUM_KEYWORDS-1:0] kw_valid;
  hkf_scan_ctl_t scan_ctl;
  logic          host_now, hit_now;

  assign s1_res    = s1_item_r.mode == MODE_PKT && s1_item_r.last;
  assign s1_fire   = s1_valid_r && (!s1_res || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_filter_enable;
    end
  end

  hkf_kw_store u_kw_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .kw_chars (kw_chars),
    .kw_len   (kw_len),
    .kw_valid (kw_valid)
  );

  hkf_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .ctl      (scan_ctl),
    .host_now (host_now)
  );

  hkf_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .ctl      (scan_ctl),
    .kw_chars (kw_chars),
    .kw_len   (kw_len),
    .kw_valid (kw_valid),
    .hit_now  (hit_now)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      out_data_r.matched    <= enable_r && hit_now;
      out_data_r.host_found <= enable_r && host_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_fire && s1_res))
    else $error("result register overwritten while held");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_res && out_valid_r))
    else $error("input stalled without a held packet end");

  a_hit_implies_host: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_res && hit_now) |-> host_now)
    else $error("keyword hit outside a host line");

endmodule

// ===== rtl/core/hkf_kw_store.sv =====
// Keyword slot storage: characters, lengths and valid flags.
`timescale 1ns / 1ps

module hkf_kw_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  hkf_pkg::hkf_in_t     item,
  output hkf_pkg::hkf_kw_bank_t kw_chars,
  output hkf_pkg::hkf_kw_lens_t kw_len,
  output logic [hkf_pkg::NUM_KEYWORDS-1:0] kw_valid
);
  import hkf_pkg::*;

  hkf_kw_bank_t                chars_r;
  hkf_kw_lens_t                len_r;
  logic [NUM_KEYWORDS-1:0]     valid_r;
  logic [KW_LEN_W-1:0]         sat_len;

  assign sat_len = (item.position > KW_LEN_W'(KEYWORD_LEN)) ?
                   KW_LEN_W'(KEYWORD_LEN) : item.position;

  always_ff @(posedge clk) begin
    if (fire && item.mode == MODE_KW_BYTE &&
        item.position < 6'(KEYWORD_LEN)) begin
      chars_r[item.slot][item.position[KW_POS_W-1:0]] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      valid_r <= '0;
    end else if (fire && item.mode == MODE_KW_LEN) begin
      len_r[item.slot]   <= sat_len;
      valid_r[item.slot] <= 1'b1;
    end else if (fire && item.mode == MODE_KW_CLEAR) begin
      len_r[item.slot]   <= '0;
      valid_r[item.slot] <= 1'b0;
    end
  end

  assign kw_chars = chars_r;
  assign kw_len   = len_r;
  assign kw_valid = valid_r;

endmodule

// ===== rtl/core/hkf_scan.sv =====
// Packet line scanner: finds the first Host line and tracks packet state.
`timescale 1ns / 1ps

module hkf_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  hkf_pkg::hkf_in_t      item,
  output hkf_pkg::hkf_scan_ctl_t ctl,
  output logic                  host_now
);
  import hkf_pkg::*;

  logic [PROG_W-1:0] prog_r, prog_upd, prog_nxt, prog_inc;
  logic              in_host_r, in_host_upd, in_host_nxt;
  logic              done_r, done_upd, done_nxt;
  logic              term_r, term_upd, term_nxt;
  logic              pkt;
  logic              text_byte, enter_host;
  logic [7:0]        b;

  assign pkt      = fire && item.mode == MODE_PKT;
  assign b        = item.data_byte;
  assign prog_inc = prog_r + PROG_W'(1);

  always_comb begin
    prog_upd    = prog_r;
    in_host_upd = in_host_r;
    done_upd    = done_r;
    term_upd    = term_r;
    text_byte   = 1'b0;
    enter_host  = 1'b0;
    if (pkt && !term_r) begin
      if (b == CHAR_NUL) begin
        term_upd = 1'b1;
        if (in_host_r) begin
          in_host_upd = 1'b0;
          done_upd    = 1'b1;
        end
      end else if (b == CHAR_CR || b == CHAR_LF) begin
        if (in_host_r) begin
          in_host_upd = 1'b0;
          done_upd    = 1'b1;
        end
        prog_upd = '0;
      end else if (in_host_r) begin
        text_byte = 1'b1;
      end else if (!done_r) begin
        if (b == HOST_PREFIX[prog_r]) begin
          if (prog_inc == PROG_W'(PREFIX_LEN)) begin
            enter_host  = 1'b1;
            in_host_upd = 1'b1;
            prog_upd    = '0;
          end else begin
            prog_upd = prog_inc;
          end
        end else begin
          prog_upd = (b == HOST_PREFIX[0]) ? PROG_W'(1) : '0;
        end
      end
    end
  end

  assign host_now = in_host_upd || done_upd;

  always_comb begin
    ctl.text_byte  = text_byte;
    ctl.enter_host = enter_host;
    ctl.pkt_end    = pkt && item.last;
    if (ctl.pkt_end) begin
      prog_nxt    = '0;
      in_host_nxt = 1'b0;
      done_nxt    = 1'b0;
      term_nxt    = 1'b0;
    end else begin
      prog_nxt    = prog_upd;
      in_host_nxt = in_host_upd;
      done_nxt    = done_upd;
      term_nxt    = term_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r    <= '0;
      in_host_r <= 1'b0;
      done_r    <= 1'b0;
      term_r    <= 1'b0;
    end else begin
      prog_r    <= prog_nxt;
      in_host_r <= in_host_nxt;
      done_r    <= done_nxt;
      term_r    <= term_nxt;
    end
  end

endmodule

// ===== rtl/core/hkf_match.sv =====
// Shift-and match vectors for all keyword slots, updated in parallel.
`timescale 1ns / 1ps

module hkf_match (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  hkf_pkg::hkf_in_t       item,
  input  hkf_pkg::hkf_scan_ctl_t ctl,
  input  hkf_pkg::hkf_kw_bank_t  kw_chars,
  input  hkf_pkg::hkf_kw_lens_t  kw_len,
  input  logic [hkf_pkg::NUM_KEYWORDS-1:0] kw_valid,
  output logic                   hit_now
);
  import hkf_pkg::*;

  logic [NUM_KEYWORDS-1:0][KEYWORD_LEN-1:0] vec_r, vec_nxt, shifted;
  logic [NUM_KEYWORDS-1:0]                  slot_hit, empty_hit;
  logic                                     hit_r;
  logic                                     kw_cfg;

  assign kw_cfg = fire && (item.mode == MODE_KW_LEN || item.mode == MODE_KW_CLEAR);

  always_comb begin
    logic [KEYWORD_LEN-1:0] eq;
    logic [KW_LEN_W-1:0]    len_m1;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      for (int i = 0; i < KEYWORD_LEN; i++) begin
        eq[i] = kw_chars[k][i] == item.data_byte;
      end
      shifted[k]   = {vec_r[k][KEYWORD_LEN-2:0], 1'b1} & eq;
      len_m1       = kw_len[k] - KW_LEN_W'(1);
      slot_hit[k]  = kw_valid[k] && kw_len[k] != '0 &&
                     shifted[k][len_m1[KW_POS_W-1:0]];
      empty_hit[k] = kw_valid[k] && kw_len[k] == '0;
      vec_nxt[k]   = vec_r[k];
      if (ctl.text_byte) vec_nxt[k] = shifted[k];
      if (ctl.enter_host || ctl.pkt_end) vec_nxt[k] = '0;
      if (kw_cfg && item.slot == SLOT_W'(k)) vec_nxt[k] = '0;
    end
  end

  assign hit_now = hit_r || (ctl.text_byte && |slot_hit) ||
                   (ctl.enter_host && |empty_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= '0;
      hit_r <= 1'b0;
    end else begin
      vec_r <= vec_nxt;
      hit_r <= ctl.pkt_end ? 1'b0 : hit_now;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the HTTP host keyword filter.
`timescale 1ns / 1ps

module tb_top;
  import hkf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  class host_verdict_board;
    logic [7:0]             kw_chars [NUM_KEYWORDS][KEYWORD_LEN];
    int unsigned            kw_len [NUM_KEYWORDS];
    bit                     kw_on [NUM_KEYWORDS];
    logic [KEYWORD_LEN-1:0] shift_vec [NUM_KEYWORDS];
    int unsigned            prefix_cnt;
    bit                     in_host, host_closed, hit, text_ended, enable;
    hkf_out_t               pending_verdicts [$];
    int unsigned            mismatch_count;

    function new();
      foreach (kw_len[k]) begin
        kw_len[k] = 0;
        kw_on[k] = 0;
      end
      enable = 0;
      mismatch_count = 0;
      reset_packet();
    endfunction

    function void reset_packet();
      foreach (shift_vec[k]) shift_vec[k] = '0;
      prefix_cnt = 0;
      in_host = 0;
      host_closed = 0;
      hit = 0;
      text_ended = 0;
    endfunction

    function void close_host();
      if (in_host) begin
        in_host = 0;
        host_closed = 1;
      end
    endfunction

    function void scan_byte(logic [7:0] b);
      logic [KEYWORD_LEN-1:0] eq;
      if (text_ended) return;
      if (b == CHAR_NUL) begin
        text_ended = 1;
        close_host();
        return;
      end
      if (b == CHAR_CR || b == CHAR_LF) begin
        close_host();
        prefix_cnt = 0;
        return;
      end
      if (in_host) begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
          for (int i = 0; i < KEYWORD_LEN; i++) eq[i] = (kw_chars[k][i] == b);
          shift_vec[k] = {shift_vec[k][KEYWORD_LEN-2:0], 1'b1} & eq;
          if (kw_on[k] && kw_len[k] != 0 && shift_vec[k][kw_len[k]-1]) hit = 1;
        end
        return;
      end
      if (host_closed) return;
      if (b == HOST_PREFIX[prefix_cnt]) prefix_cnt++;
      else prefix_cnt = (b == HOST_PREFIX[0]) ? 1 : 0;
      if (prefix_cnt == PREFIX_LEN) begin
        in_host = 1;
        prefix_cnt = 0;
        foreach (shift_vec[k]) begin
          shift_vec[k] = '0;
          if (kw_on[k] && kw_len[k] == 0) hit = 1;
        end
      end
    endfunction

    function void note_item(hkf_in_t it);
      hkf_out_t v;
      case (it.mode)
        MODE_KW_BYTE: begin
          if (it.position < KEYWORD_LEN)
            kw_chars[it.slot][it.position[KW_POS_W-1:0]] = it.data_byte;
        end
        MODE_KW_LEN: begin
          kw_len[it.slot] = (it.position > KEYWORD_LEN) ? KEYWORD_LEN : it.position;
          kw_on[it.slot] = 1;
          shift_vec[it.slot] = '0;
        end
        MODE_KW_CLEAR: begin
          kw_len[it.slot] = 0;
          kw_on[it.slot] = 0;
          shift_vec[it.slot] = '0;
        end
        MODE_PKT: begin
          scan_byte(it.data_byte);
          if (it.last) begin
            v.matched = enable && hit;
            v.host_found = enable && (in_host || host_closed);
            pending_verdicts.push_back(v);
            reset_packet();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(hkf_out_t got);
      hkf_out_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transaction matched=%0b host_found=%0b",
                 $time, got.matched, got.host_found);
        mismatch_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.matched !== want.matched) begin
        $display("%0t: matched expected %0b actual %0b", $time, want.matched, got.matched);
        mismatch_count++;
      end
      if (got.host_found !== want.host_found) begin
        $display("%0t: host_found expected %0b actual %0b",
                 $time, want.host_found, got.host_found);
        mismatch_count++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  hkf_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hkf_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_filter_enable;

  host_verdict_board board;
  logic [7:0]        pkt_bytes [$];
  int unsigned       items_sent = 0;
  int unsigned       rx_hold = 0;
  bit                tx_idle_en = 1;
  bit                rx_stall_en = 1;

  http_host_keyword_filter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_filter_enable (cfg_filter_enable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 99) < 20) begin
      rx_hold <= stall_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_verdict(out_data);
  end

  function automatic hkf_in_t make_item(hkf_mode_t m, int unsigned s, int unsigned p,
                                        logic [7:0] b, bit l);
    hkf_in_t it;
    it.mode = m;
    it.slot = s[SLOT_W-1:0];
    it.position = p[5:0];
    it.data_byte = b;
    it.last = l;
    return it;
  endfunction

  function automatic logic [7:0] host_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'(8'h61 + $urandom_range(0, 4));
    if (r < 82) return 8'h2E;
    if (r < 94) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) pkt_bytes.push_back(s[i]);
  endfunction

  function automatic void add_filler(int unsigned n);
    repeat (n) pkt_bytes.push_back(host_char());
  endfunction

  function automatic void add_noise(int unsigned n);
    int unsigned r;
    repeat (n) begin
      if ($urandom_range(0, 99) < 40) begin
        r = $urandom_range(0, 8);
        if (r < PREFIX_LEN) pkt_bytes.push_back(HOST_PREFIX[r]);
        else if (r == 6) pkt_bytes.push_back(CHAR_CR);
        else if (r == 7) pkt_bytes.push_back(CHAR_LF);
        else pkt_bytes.push_back(CHAR_NUL);
      end else begin
        pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // pick < 0 selects any valid non-empty keyword
  function automatic void add_keyword(int pick);
    int unsigned pool [$];
    int unsigned s;
    if (pick >= 0) begin
      s = pick;
    end else begin
      for (int k = 0; k < NUM_KEYWORDS; k++)
        if (board.kw_on[k] && board.kw_len[k] != 0) pool.push_back(k);
      if (pool.size() == 0) return;
      s = pool[$urandom_range(0, pool.size() - 1)];
    end
    for (int i = 0; i < board.kw_len[s]; i++) pkt_bytes.push_back(board.kw_chars[s][i]);
  endfunction

  task automatic send_item(input hkf_in_t it);
    int unsigned gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
    items_sent++;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_enable(input bit en);
    cfg_filter_enable <= en;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.enable = en;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int unsigned n;
    in_valid <= 1'b0;
    n = 0;
    while (board.pending_verdicts.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_keyword(input int unsigned s, input int unsigned n);
    for (int unsigned p = 0; p < n; p++)
      send_item(make_item(MODE_KW_BYTE, s, p, 8'(8'h61 + $urandom_range(0, 4)), 1'b0));
    send_item(make_item(MODE_KW_LEN, s,
                        (n == KEYWORD_LEN) ? $urandom_range(KEYWORD_LEN, 63) : n,
                        8'h00, 1'b0));
  endtask

  task automatic random_kw_op();
    int unsigned r, s, p;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, NUM_KEYWORDS - 1);
    if (r < 40) begin
      if ($urandom_range(0, 99) < 20)
        send_item(make_item(MODE_KW_BYTE, s, $urandom_range(KEYWORD_LEN, 63),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      else
        send_item(make_item(MODE_KW_BYTE, s, $urandom_range(0, KEYWORD_LEN - 1),
                            host_char(), 1'($urandom_range(0, 1))));
    end else if (r < 70) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        s = NUM_KEYWORDS - 1;
        p = 0;
      end else if (r < 65) begin
        p = $urandom_range(1, 5);
      end else if (r < 85) begin
        p = $urandom_range(6, KEYWORD_LEN);
      end else begin
        p = $urandom_range(KEYWORD_LEN + 1, 63);
      end
      send_item(make_item(MODE_KW_LEN, s, p, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))));
    end else begin
      if ($urandom_range(0, 1)) s = NUM_KEYWORDS - 1;
      send_item(make_item(MODE_KW_CLEAR, s, $urandom_range(0, 63),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic send_packet(input bit close_pkt, input bit mix_ops);
    for (int unsigned i = 0; i < pkt_bytes.size(); i++) begin
      if (mix_ops && $urandom_range(0, 99) < 6) random_kw_op();
      send_item(make_item(MODE_PKT, $urandom_range(0, 15), $urandom_range(0, 63), pkt_bytes[i],
                          close_pkt && i == pkt_bytes.size() - 1));
    end
    pkt_bytes.delete();
  endtask

  function automatic void build_packet();
    int unsigned r;
    bit          ended;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      if ($urandom_range(0, 1)) add_text("GET / HTTP/1.1\r\n");
      repeat ($urandom_range(0, 1)) begin
        add_text("Via: ");
        add_filler($urandom_range(0, 4));
        add_text("\r\n");
      end
      add_text("Host: ");
      add_filler($urandom_range(0, 4));
      if ($urandom_range(0, 99) < 65) add_keyword(-1);
      add_filler($urandom_range(0, 4));
      ended = 1;
      case ($urandom_range(0, 5))
        0: add_text("\r\n");
        1: add_text("\n");
        2: add_text("\r");
        3: pkt_bytes.push_back(CHAR_NUL);
        default: ended = 0;
      endcase
      if (ended && $urandom_range(0, 99) < 40) begin
        add_text("Host: ");
        add_keyword(-1);
      end
      if (ended && $urandom_range(0, 99) < 15) begin
        pkt_bytes.push_back(CHAR_NUL);
        add_noise($urandom_range(1, 5));
      end
    end else if (r < 90) begin
      case ($urandom_range(0, 5))
        0: add_text("Host:");
        1: add_text("Host :");
        2: add_text("HHost: ");
        3: add_text("host: ");
        4: add_text("Hos\nt: ");
        default: add_text("HoHost: ");
      endcase
      add_filler($urandom_range(0, 3));
      add_keyword(-1);
      add_noise($urandom_range(0, 3));
    end else begin
      add_noise($urandom_range(1, 16));
    end
    if (pkt_bytes.size() == 0) add_text("x");
  endfunction

  task automatic run_phase(input int unsigned n_items, input int unsigned n_pkts,
                           input bit vary_idle);
    int unsigned start, pkts;
    start = items_sent;
    pkts = 0;
    while (items_sent - start < n_items || pkts < n_pkts) begin
      if (vary_idle && $urandom_range(0, 99) < 8) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_stall_en = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < 15) random_kw_op();
      if ($urandom_range(0, 99) < 5)
        program_keyword($urandom_range(0, 11),
                        ($urandom_range(0, 99) < 10) ? KEYWORD_LEN : $urandom_range(1, 6));
      build_packet();
      send_packet(1'b1, $urandom_range(0, 99) < 20);
      pkts++;
    end
  endtask

  initial begin
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_filter_enable <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every keyword byte gets a defined value before any host text is scanned
    for (int s = 0; s < NUM_KEYWORDS; s++)
      for (int p = 0; p < KEYWORD_LEN; p++)
        send_item(make_item(MODE_KW_BYTE, s, p, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
    for (int s = 0; s < 12; s++) program_keyword(s, $urandom_range(1, 4));
    program_keyword(12, KEYWORD_LEN);
    send_item(make_item(MODE_KW_LEN, 13, 63, 8'h00, 1'b0));

    // filter still disabled after reset
    add_text("Host: ");
    add_keyword(0);
    add_text("\r\n");
    send_packet(1'b1, 1'b0);
    wait_drained();
    write_enable(1'b1);

    add_text("Host: ");
    add_keyword(0);
    send_packet(1'b1, 1'b0);
    add_text("Host: zz\r\n");
    send_packet(1'b1, 1'b0);
    add_text("GET /\n");
    send_packet(1'b1, 1'b0);
    add_text("Host: ");
    pkt_bytes.push_back(CHAR_NUL);
    add_keyword(0);
    send_packet(1'b1, 1'b0);
    add_text("xHost: zz\rHost: ");
    add_keyword(0);
    send_packet(1'b1, 1'b0);

    // empty keyword hits on any host line
    send_item(make_item(MODE_KW_LEN, NUM_KEYWORDS - 1, 0, 8'h00, 1'b1));
    add_text("Host: ");
    send_packet(1'b1, 1'b0);
    send_item(make_item(MODE_KW_CLEAR, NUM_KEYWORDS - 1, 0, 8'h00, 1'b0));
    send_item(make_item(MODE_KW_BYTE, 0, 40, 8'hFF, 1'b0));

    // relength slot 0 in the middle of its own match
    add_text("Host: ");
    pkt_bytes.push_back(board.kw_chars[0][0]);
    send_packet(1'b0, 1'b0);
    send_item(make_item(MODE_KW_LEN, 0, board.kw_len[0], 8'h00, 1'b0));
    for (int i = 1; i < board.kw_len[0]; i++) pkt_bytes.push_back(board.kw_chars[0][i]);
    add_text("q");
    send_packet(1'b1, 1'b0);
    pkt_bytes.push_back(8'hA5);
    send_packet(1'b1, 1'b0);

    run_phase(200, 8, 1'b1);
    wait_drained();
    run_phase(50, 2, 1'b1);
    wait_drained();
    write_enable(1'b0);
    run_phase(100, 4, 1'b1);
    wait_drained();
    write_enable(1'b1);
    tx_idle_en = 0;
    rx_stall_en = 0;
    run_phase(100, 4, 1'b0);
    tx_idle_en = 1;
    rx_stall_en = 1;
    run_phase(200, 8, 1'b1);
    wait_drained();

    if (board.pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected result transactions never arrived",
               $time, board.pending_verdicts.size());
      board.mismatch_count++;
    end
    if (board.mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hkf_pkg.sv
rtl/core/hkf_kw_store.sv
rtl/core/hkf_scan.sv
rtl/core/hkf_match.sv
rtl/core/http_host_keyword_filter.sv
sim/tb_top.sv
